@@ sv/generational_write_barrier_top_macros.svh @@
// Assertion macros shared by the write barrier checker.
// Depends on nothing; a module that includes this file must provide clk and rst_n.
`ifndef GENERATIONAL_WRITE_BARRIER_TOP_MACROS_SVH
`define GENERATIONAL_WRITE_BARRIER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define GWB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("write barrier check failed");

// The consequent holds in the cycle after the antecedent.
`define GWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("write barrier check failed");

`endif

@@ sv/gwb_pkg.sv @@
// Package for the generational write barrier: codes, widths and shared types.
// Depends on nothing; used by every module of the block.
`default_nettype none
package gwb_pkg;

  localparam int ADDR_W      = 32;
  localparam int GB_W        = 30;
  localparam int CAP_W       = 9;
  localparam int GEN_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REM_CAP   = 2'd2;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'd0;
  localparam logic [GB_W-1:0]   GEN_BYTES_RST = 30'd1048576;
  localparam logic [CAP_W-1:0]  REM_CAP_RST   = 9'd511;

  localparam logic [STATUS_W-1:0] ST_GLOBAL   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RECORDED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_VALUE,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic             in_heap;
    logic [GEN_W-1:0] gen;
  } gen_res_t;

endpackage
`default_nettype wire

@@ sv/generational_write_barrier_top.sv @@
// Generational write barrier with per-generation remembered sets: the top
// level with the sequencer, configuration registers and output register.
// Depends on gwb_pkg, gwb_gen_unit and gwb_remset.
//
// A clear beat goes from idle straight to the done state. A store beat
// finds the slot generation and then the value generation in turn with
// one shared add-and-compare unit and, when the slot is in an older
// generation than the value, scans the n entries of the value
// generation's remembered set, one memory read a cycle. The input is not
// ready while a beat is in work, but it is ready again while the previous
// result still waits in the output register.
`default_nettype none
module generational_write_barrier_top #(
  parameter int GENERATIONS    = 5,
  parameter int REMEMBER_DEPTH = 512
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // opcode
  input  wire logic                                in_tuser,
  // slot_address, value_address, clear_generation, zero fill
  input  wire logic [gwb_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // status, slot_generation, value_generation, zero fill
  output logic      [gwb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [gwb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gwb_pkg::ADDR_W-1:0]          cfg_wdata
);

  localparam int GI_W  = $clog2(GENERATIONS);
  localparam int IDX_W = $clog2(REMEMBER_DEPTH);
  localparam int CNT_W = $clog2(REMEMBER_DEPTH + 1);
  localparam int CMP_W = (CNT_W > gwb_pkg::CAP_W) ? CNT_W : gwb_pkg::CAP_W;

  gwb_pkg::state_t state_r, state_nxt;

  logic [gwb_pkg::ADDR_W-1:0]   base_r;
  logic [gwb_pkg::GB_W-1:0]     gb_r;
  logic [gwb_pkg::CAP_W-1:0]    cap_r;

  logic [gwb_pkg::ADDR_W-1:0]   slot_r;
  logic [gwb_pkg::ADDR_W-1:0]   value_r;
  logic [gwb_pkg::GEN_W-1:0]    sg_r;
  logic [gwb_pkg::GEN_W-1:0]    vg_r;
  logic [gwb_pkg::STATUS_W-1:0] status_r;
  logic [CNT_W-1:0]             idx_r;
  logic                         pend_r;

  logic                         out_valid_r;
  logic [gwb_pkg::STATUS_W-1:0] out_status_r;
  logic [gwb_pkg::GEN_W-1:0]    out_sg_r;
  logic [gwb_pkg::GEN_W-1:0]    out_vg_r;

  logic                         in_op;
  logic [gwb_pkg::ADDR_W-1:0]   in_slot;
  logic [gwb_pkg::ADDR_W-1:0]   in_value;
  logic [gwb_pkg::GEN_W-1:0]    in_cg;
  logic                         in_acc;
  logic                         cg_ok;

  gwb_pkg::gen_res_t            gen_res;
  logic                         gen_start;
  logic [gwb_pkg::ADDR_W-1:0]   gen_addr;

  logic [gwb_pkg::ADDR_W-1:0]   rd_data;
  logic [CNT_W-1:0]             cnt;
  logic                         wr_en;
  logic                         clr_en;
  logic                         out_load;

  logic                         more;
  logic                         hit;
  logic                         scan_end;
  logic [CMP_W-1:0]             cap_ext;
  logic [CMP_W-1:0]             capm;
  logic                         full;
  logic                         older;

  assign in_op    = in_tuser;
  assign in_slot  = in_tdata[31:0];
  assign in_value = in_tdata[63:32];
  assign in_cg    = in_tdata[66:64];
  assign in_acc   = in_tvalid && in_tready;
  assign cg_ok    = ({1'b0, in_cg} < 4'(GENERATIONS));

  assign more     = (idx_r < cnt);
  assign hit      = pend_r && (rd_data == slot_r);
  assign scan_end = !pend_r && !more;
  assign cap_ext  = CMP_W'(cap_r);
  assign capm     = (cap_ext > CMP_W'(REMEMBER_DEPTH)) ? CMP_W'(REMEMBER_DEPTH) : cap_ext;
  assign full     = (CMP_W'(cnt) >= capm);
  assign older    = (sg_r > gen_res.gen);

  gwb_gen_unit #(
    .GENERATIONS(GENERATIONS)
  ) u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gen_start),
    .addr  (gen_addr),
    .base  (base_r),
    .gb    (gb_r),
    .res   (gen_res)
  );

  gwb_remset #(
    .GENERATIONS   (GENERATIONS),
    .REMEMBER_DEPTH(REMEMBER_DEPTH)
  ) u_remset (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_gen  (vg_r[GI_W-1:0]),
    .rd_idx  (idx_r[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_gen  (vg_r[GI_W-1:0]),
    .wr_data (slot_r),
    .clr_en  (clr_en),
    .clr_gen (in_cg[GI_W-1:0]),
    .cnt_gen (vg_r[GI_W-1:0]),
    .cnt     (cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= gwb_pkg::HEAP_BASE_RST;
      gb_r   <= gwb_pkg::GEN_BYTES_RST;
      cap_r  <= gwb_pkg::REM_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gwb_pkg::CFG_HEAP_BASE: base_r <= cfg_wdata;
        gwb_pkg::CFG_GEN_BYTES: gb_r   <= cfg_wdata[gwb_pkg::GB_W-1:0];
        gwb_pkg::CFG_REM_CAP:   cap_r  <= cfg_wdata[gwb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gwb_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_op == gwb_pkg::OP_CLEAR) ? gwb_pkg::S_DONE : gwb_pkg::S_SLOT;
        end
      end
      gwb_pkg::S_SLOT: begin
        if (gen_res.done) begin
          state_nxt = gen_res.in_heap ? gwb_pkg::S_VALUE : gwb_pkg::S_DONE;
        end
      end
      gwb_pkg::S_VALUE: begin
        if (gen_res.done) begin
          state_nxt = (gen_res.in_heap && older) ? gwb_pkg::S_SEARCH : gwb_pkg::S_DONE;
        end
      end
      gwb_pkg::S_SEARCH: begin
        if (hit || scan_end) begin
          state_nxt = gwb_pkg::S_DONE;
        end
      end
      gwb_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = gwb_pkg::S_IDLE;
        end
      end
      default: state_nxt = gwb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == gwb_pkg::S_IDLE);
    gen_start = 1'b0;
    gen_addr  = value_r;
    clr_en    = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      gwb_pkg::S_IDLE: begin
        gen_addr  = in_slot;
        gen_start = in_acc && (in_op == gwb_pkg::OP_STORE);
        clr_en    = in_acc && (in_op == gwb_pkg::OP_CLEAR) && cg_ok;
      end
      gwb_pkg::S_SLOT: begin
        gen_start = gen_res.done && gen_res.in_heap;
      end
      gwb_pkg::S_SEARCH: begin
        wr_en = !hit && scan_end && !full;
      end
      gwb_pkg::S_DONE: begin
        out_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gwb_pkg::S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gwb_pkg::S_SEARCH) begin
        pend_r <= more;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gwb_pkg::S_IDLE: begin
        if (in_acc) begin
          slot_r  <= in_slot;
          value_r <= in_value;
          sg_r    <= '0;
          vg_r    <= '0;
          if (in_op == gwb_pkg::OP_CLEAR) begin
            status_r <= cg_ok ? gwb_pkg::ST_CLEARED : gwb_pkg::ST_NOTHING;
          end
        end
      end
      gwb_pkg::S_SLOT: begin
        if (gen_res.done) begin
          if (!gen_res.in_heap) begin
            status_r <= gwb_pkg::ST_GLOBAL;
          end else begin
            sg_r <= gen_res.gen;
          end
        end
      end
      gwb_pkg::S_VALUE: begin
        idx_r <= '0;
        if (gen_res.done) begin
          vg_r <= gen_res.gen;
          if (!gen_res.in_heap || !older) begin
            status_r <= gwb_pkg::ST_NOTHING;
          end
        end
      end
      gwb_pkg::S_SEARCH: begin
        if (more) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (hit) begin
          status_r <= gwb_pkg::ST_ALREADY;
        end else if (scan_end) begin
          status_r <= full ? gwb_pkg::ST_OVERFLOW : gwb_pkg::ST_RECORDED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_sg_r     <= sg_r;
      out_vg_r     <= vg_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_vg_r, out_sg_r, out_status_r};

endmodule
`default_nettype wire

@@ sv/gwb_gen_unit.sv @@
// Shared generation unit: subtracts the heap base, then finds the generation
// by repeated add and compare against the generation size. Uses gwb_pkg.
`default_nettype none
module gwb_gen_unit #(
  parameter int GENERATIONS = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [gwb_pkg::ADDR_W-1:0]  addr,
  input  wire logic [gwb_pkg::ADDR_W-1:0]  base,
  input  wire logic [gwb_pkg::GB_W-1:0]    gb,
  output gwb_pkg::gen_res_t                res
);

  localparam int K_W   = $clog2(GENERATIONS + 1);
  localparam int ACC_W = gwb_pkg::ADDR_W + 2;

  logic                       busy_r;
  logic                       below_r;
  logic [gwb_pkg::ADDR_W-1:0] off_r;
  logic [ACC_W-1:0]           acc_r;
  logic [K_W-1:0]             k_r;
  logic [gwb_pkg::GB_W-1:0]   gbe;
  logic [gwb_pkg::ADDR_W:0]   diff;
  logic                       top_hit;
  logic                       stop;
  logic                       in_heap;

  assign gbe     = (gb == '0) ? gwb_pkg::GB_W'(1) : gb;
  assign diff    = {1'b0, addr} - {1'b0, base};
  assign top_hit = (k_r == K_W'(GENERATIONS));
  assign stop    = below_r || top_hit || ({2'b00, off_r} < acc_r);
  assign in_heap = !below_r && !top_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && stop) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      off_r   <= diff[gwb_pkg::ADDR_W-1:0];
      below_r <= diff[gwb_pkg::ADDR_W];
      acc_r   <= ACC_W'(gbe);
      k_r     <= '0;
    end else if (busy_r && !stop) begin
      acc_r <= acc_r + ACC_W'(gbe);
      k_r   <= k_r + K_W'(1);
    end
  end

  assign res.done    = busy_r && stop;
  assign res.in_heap = in_heap;
  assign res.gen     = in_heap ? gwb_pkg::GEN_W'(k_r) : '0;

endmodule
`default_nettype wire

@@ sv/gwb_remset.sv @@
// Remembered sets: one slot memory per generation with registered reads,
// plus the per-generation fill counts. Uses gwb_pkg.
`default_nettype none
module gwb_remset #(
  parameter int GENERATIONS    = 5,
  parameter int REMEMBER_DEPTH = 512
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [$clog2(GENERATIONS)-1:0]     rd_gen,
  input  wire logic [$clog2(REMEMBER_DEPTH)-1:0]  rd_idx,
  output logic      [gwb_pkg::ADDR_W-1:0]         rd_data,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(GENERATIONS)-1:0]     wr_gen,
  input  wire logic [gwb_pkg::ADDR_W-1:0]         wr_data,
  input  wire logic                               clr_en,
  input  wire logic [$clog2(GENERATIONS)-1:0]     clr_gen,
  input  wire logic [$clog2(GENERATIONS)-1:0]     cnt_gen,
  output logic      [$clog2(REMEMBER_DEPTH+1)-1:0] cnt
);

  localparam int IDX_W = $clog2(REMEMBER_DEPTH);
  localparam int CNT_W = $clog2(REMEMBER_DEPTH + 1);

  logic [gwb_pkg::ADDR_W-1:0] mem [GENERATIONS][REMEMBER_DEPTH];
  logic [CNT_W-1:0]           cnt_r [GENERATIONS];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_gen][rd_idx];
    if (wr_en) begin
      mem[wr_gen][cnt_r[wr_gen][IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GENERATIONS; g++) begin
        cnt_r[g] <= '0;
      end
    end else begin
      if (clr_en) begin
        cnt_r[clr_gen] <= '0;
      end
      if (wr_en) begin
        cnt_r[wr_gen] <= cnt_r[wr_gen] + CNT_W'(1);
      end
    end
  end

  assign cnt = cnt_r[cnt_gen];

endmodule
`default_nettype wire

@@ sv/gwb_checker.sv @@
// Port-level checker for the generational write barrier and its bind.
// Depends on gwb_pkg, the assertion macros header and the top level.
`default_nettype none
`include "generational_write_barrier_top_macros.svh"
module gwb_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [gwb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [gwb_pkg::STATUS_W-1:0] st;
  logic [gwb_pkg::GEN_W-1:0]    sg;
  logic [gwb_pkg::GEN_W-1:0]    vg;
  logic                         set_touched;

  assign st = out_tdata[2:0];
  assign sg = out_tdata[5:3];
  assign vg = out_tdata[8:6];
  assign set_touched = (st == gwb_pkg::ST_ALREADY) || (st == gwb_pkg::ST_RECORDED) ||
                       (st == gwb_pkg::ST_OVERFLOW);

  `GWB_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)
  `GWB_ASSERT_NEXT(a_out_held, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `GWB_ASSERT_SAME(a_global_no_gen, out_tvalid && (st == gwb_pkg::ST_GLOBAL), sg == '0 && vg == '0)
  `GWB_ASSERT_SAME(a_clear_no_gen, out_tvalid && (st == gwb_pkg::ST_CLEARED), sg == '0 && vg == '0)
  `GWB_ASSERT_SAME(a_set_needs_older, out_tvalid && set_touched, sg > vg)

endmodule

bind generational_write_barrier_top gwb_checker u_gwb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for generational_write_barrier_top: barrier beats go in through a
// queue-fed driver, results are checked against an in-bench remembered-set predictor.
// Depends on gwb_pkg and the generational_write_barrier_top RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int NGEN        = 5;
  localparam int DEPTH       = 512;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 600;
  localparam logic [gwb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {MIX_NONE, MIX_SEND, MIX_RECV, MIX_BOTH} idle_mix_t;

  typedef struct packed {
    logic [gwb_pkg::GEN_W-1:0]    vg;
    logic [gwb_pkg::GEN_W-1:0]    sg;
    logic [gwb_pkg::STATUS_W-1:0] status;
  } barrier_res_t;

  typedef struct packed {
    logic                             op;
    logic [gwb_pkg::IN_TDATA_W-1:0]   data;
  } beat_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic                            in_tuser;
  logic [gwb_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [gwb_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we;
  logic [gwb_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [gwb_pkg::ADDR_W-1:0]      cfg_wdata;

  // Predictor copy of the registers and the remembered sets.
  logic [gwb_pkg::ADDR_W-1:0] heap_base_m;
  logic [gwb_pkg::GB_W-1:0]   gen_bytes_m;
  logic [gwb_pkg::CAP_W-1:0]  capacity_m;
  logic [gwb_pkg::ADDR_W-1:0] remset_m [NGEN][DEPTH];
  int unsigned                remcount_m [NGEN];

  beat_t                      beats_queued [$];
  barrier_res_t               barrier_verdicts_due [$];
  logic [gwb_pkg::ADDR_W-1:0] slot_pool [NGEN][$];

  int send_gap_pct;
  int recv_stall_pct;
  int hold_token;
  int hold_seen;
  int hold_left;
  int error_count;
  int beats_checked;
  int layouts_written;
  int status_tally [6];

  generational_write_barrier_top #(
    .GENERATIONS   (NGEN),
    .REMEMBER_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] eff_gen_bytes();
    return (gen_bytes_m == '0) ? 64'd1 : {34'd0, gen_bytes_m};
  endfunction

  function automatic logic addr_in_heap(logic [gwb_pkg::ADDR_W-1:0] a);
    logic [63:0] hend;
    hend = {32'd0, heap_base_m} + 64'(NGEN) * eff_gen_bytes();
    return ({32'd0, a} >= {32'd0, heap_base_m}) && ({32'd0, a} < hend);
  endfunction

  function automatic logic [gwb_pkg::GEN_W-1:0] gen_of(logic [gwb_pkg::ADDR_W-1:0] a);
    logic [63:0] g;
    g = ({32'd0, a} - {32'd0, heap_base_m}) / eff_gen_bytes();
    if (g >= 64'(NGEN)) g = 64'(NGEN - 1);
    return g[gwb_pkg::GEN_W-1:0];
  endfunction

  function automatic barrier_res_t predict_barrier(logic op,
                                                   logic [gwb_pkg::IN_TDATA_W-1:0] d);
    logic [gwb_pkg::ADDR_W-1:0] slot;
    logic [gwb_pkg::ADDR_W-1:0] value;
    logic [gwb_pkg::GEN_W-1:0]  cg;
    logic                       found;
    int unsigned                n;
    barrier_res_t               r;
    slot  = d[31:0];
    value = d[63:32];
    cg    = d[66:64];
    r     = '0;
    if (op == gwb_pkg::OP_CLEAR) begin
      if (cg < NGEN) begin
        remcount_m[cg] = 0;
        r.status = gwb_pkg::ST_CLEARED;
      end else begin
        r.status = gwb_pkg::ST_NOTHING;
      end
    end else if (!addr_in_heap(slot)) begin
      r.status = gwb_pkg::ST_GLOBAL;
    end else begin
      r.sg = gen_of(slot);
      if (!addr_in_heap(value)) begin
        r.status = gwb_pkg::ST_NOTHING;
      end else begin
        r.vg = gen_of(value);
        if (r.sg <= r.vg) begin
          r.status = gwb_pkg::ST_NOTHING;
        end else begin
          found = 1'b0;
          n = remcount_m[r.vg];
          for (int i = 0; i < n; i++) begin
            if (remset_m[r.vg][i] == slot) found = 1'b1;
          end
          if (found) begin
            r.status = gwb_pkg::ST_ALREADY;
          end else if (n >= capacity_m || n >= DEPTH) begin
            r.status = gwb_pkg::ST_OVERFLOW;
          end else begin
            remset_m[r.vg][n] = slot;
            remcount_m[r.vg] = n + 1;
            r.status = gwb_pkg::ST_RECORDED;
          end
        end
      end
    end
    return r;
  endfunction

  // Driver: holds a beat until it is taken, then offers the next or idles.
  always @(posedge clk) begin : drive_proc
    beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (beats_queued.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nb = beats_queued.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nb.op;
        in_tdata  <= nb.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the token moves.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen  <= 0;
      hold_left  <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each result beat against the oldest prediction, then predicts
  // for any input beat taken at this edge.
  always @(posedge clk) begin : check_proc
    barrier_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (barrier_verdicts_due.size() == 0) begin
          $error("unexpected result beat: status %0d", out_tdata[2:0]);
          error_count++;
        end else begin
          want = barrier_verdicts_due.pop_front();
          beats_checked++;
          if (out_tdata[2:0] < 6) status_tally[out_tdata[2:0]]++;
          if (out_tdata[2:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
            error_count++;
          end
          if (out_tdata[5:3] !== want.sg) begin
            $error("slot_generation: expected %0d, got %0d", want.sg, out_tdata[5:3]);
            error_count++;
          end
          if (out_tdata[8:6] !== want.vg) begin
            $error("value_generation: expected %0d, got %0d", want.vg, out_tdata[8:6]);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        barrier_verdicts_due.push_back(predict_barrier(in_tuser, in_tdata));
      end
    end
  end

  task automatic queue_beat(input logic op, input logic [gwb_pkg::ADDR_W-1:0] s,
                            input logic [gwb_pkg::ADDR_W-1:0] v,
                            input logic [gwb_pkg::GEN_W-1:0] cg);
    beat_t b;
    b.op   = op;
    b.data = {5'd0, cg, v, s};
    beats_queued.push_back(b);
  endtask

  task automatic set_mix(input idle_mix_t m);
    @(negedge clk);
    case (m)
      MIX_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      MIX_SEND: begin send_gap_pct = 73; recv_stall_pct = 0;  end
      MIX_RECV: begin send_gap_pct = 0;  recv_stall_pct = 73; end
      default:  begin send_gap_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  // Writes all registers; the spare index must leave them untouched.
  task automatic set_layout(input logic [gwb_pkg::ADDR_W-1:0] b,
                            input logic [gwb_pkg::ADDR_W-1:0] g,
                            input logic [gwb_pkg::ADDR_W-1:0] c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= gwb_pkg::CFG_HEAP_BASE;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_index <= gwb_pkg::CFG_GEN_BYTES;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_index <= gwb_pkg::CFG_REM_CAP;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_base_m = b;
    gen_bytes_m = g[gwb_pkg::GB_W-1:0];
    capacity_m  = c[gwb_pkg::CAP_W-1:0];
    layouts_written++;
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    while (beats_queued.size() != 0 || in_tvalid || barrier_verdicts_due.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [gwb_pkg::ADDR_W-1:0] pick_addr(int g);
    logic [63:0] gb;
    logic [63:0] a;
    gb = eff_gen_bytes();
    a = {32'd0, heap_base_m} + 64'(g) * gb + ({$urandom, $urandom} % gb);
    if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF - 64'($urandom_range(3));
    return a[gwb_pkg::ADDR_W-1:0];
  endfunction

  // Mostly old-to-young stores over a small slot pool, with clears and noise mixed in.
  task automatic queue_random(input int count);
    int r;
    int sg;
    int vg;
    logic [gwb_pkg::ADDR_W-1:0] slot;
    for (int g = 0; g < NGEN; g++) slot_pool[g].delete();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_beat(gwb_pkg::OP_CLEAR, $urandom, $urandom,
                   3'(($urandom_range(3) == 0) ? $urandom_range(7, 5) : $urandom_range(4)));
      end else if (r < 16) begin
        queue_beat(gwb_pkg::OP_STORE, $urandom, $urandom, 3'($urandom_range(7)));
      end else if (r < 24) begin
        queue_beat(gwb_pkg::OP_STORE, pick_addr($urandom_range(4)), $urandom,
                   3'($urandom_range(7)));
      end else if (r < 32) begin
        vg = $urandom_range(4);
        sg = $urandom_range(vg);
        queue_beat(gwb_pkg::OP_STORE, pick_addr(sg), pick_addr(vg), 3'($urandom_range(7)));
      end else begin
        sg = $urandom_range(4, 1);
        vg = $urandom_range(sg - 1);
        if (slot_pool[sg].size() != 0 && $urandom_range(1) == 0) begin
          slot = slot_pool[sg][$urandom_range(slot_pool[sg].size() - 1)];
        end else begin
          slot = pick_addr(sg);
          if (slot_pool[sg].size() < 12) slot_pool[sg].push_back(slot);
        end
        queue_beat(gwb_pkg::OP_STORE, slot, pick_addr(vg), 3'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    logic [gwb_pkg::ADDR_W-1:0] slot;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    hold_token  = 0;
    error_count = 0;
    beats_checked   = 0;
    layouts_written = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    heap_base_m = gwb_pkg::HEAP_BASE_RST;
    gen_bytes_m = gwb_pkg::GEN_BYTES_RST;
    capacity_m  = gwb_pkg::REM_CAP_RST;
    foreach (remcount_m[i]) remcount_m[i] = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats on the reset layout: heap 0 .. 5 MiB.
    set_mix(MIX_BOTH);
    queue_beat(gwb_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h0, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0050_0000, 32'h0, 3'd7);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_0000, 32'h0, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h004F_FFFF, 32'h0, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h004F_FFFF, 32'h0, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h004F_FFFF, 32'hFFFF_FFFF, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0010_0000, 32'h000F_FFFF, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0020_0000, 32'h0010_0000, 3'd0);
    queue_beat(gwb_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h004F_FFFF, 32'h0, 3'd0);
    queue_beat(gwb_pkg::OP_CLEAR, 32'h0, 32'h0, 3'd5);
    queue_beat(gwb_pkg::OP_CLEAR, 32'h0, 32'h0, 3'd7);
    queue_beat(gwb_pkg::OP_CLEAR, 32'h0, 32'h0, 3'd4);
    drain();

    // Zero generation size and a set that fills after two entries.
    set_layout(32'h0000_0100, 32'h0, 32'd2);
    queue_beat(gwb_pkg::OP_CLEAR, 32'h0, 32'h0, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_0104, 32'h0000_0100, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_0103, 32'h0000_0100, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_0102, 32'h0000_0100, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_0101, 32'h0000_0100, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_0103, 32'h0000_0100, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'h0000_00FF, 32'h0000_0100, 3'd0);
    drain();

    // Heap running past the top of the address space, zero capacity, masked size bits.
    set_layout(32'hC000_0000, 32'hD000_0000, 32'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'hFFFF_FFFF, 32'hC000_0000, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'hBFFF_FFFF, 32'hC000_0000, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
    drain();
    set_layout(32'hFFFF_FFFF, 32'd1, 32'd511);
    queue_beat(gwb_pkg::OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
    queue_beat(gwb_pkg::OP_STORE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 3'd0);
    drain();

    // Fill generation 0's set to full capacity behind a long output hold-off.
    set_layout(32'h0, 32'd1048576, 32'd511);
    set_mix(MIX_NONE);
    queue_beat(gwb_pkg::OP_CLEAR, 32'h0, 32'h0, 3'd0);
    for (int i = 0; i < 520; i++) begin
      slot = 32'h0010_0000 * 32'(1 + i % 4) + 32'(i * 8);
      queue_beat(gwb_pkg::OP_STORE, slot, $urandom_range(32'h000F_FFFF, 0),
                 3'($urandom_range(7)));
    end
    for (int i = 0; i < 6; i++) begin
      slot = 32'h0010_0000 * 32'(1 + i % 4) + 32'(i * 8);
      queue_beat(gwb_pkg::OP_STORE, slot, $urandom_range(32'h000F_FFFF, 0),
                 3'($urandom_range(7)));
    end
    hold_token++;
    drain();

    set_layout($urandom, $urandom_range(4096, 1), 32'd8);
    set_mix(MIX_SEND);
    queue_random(155);
    drain();

    set_layout(32'h0, 32'd858993459, 32'd1);
    set_mix(MIX_RECV);
    queue_random(155);
    drain();

    set_layout(32'hFFFF_FFF0, 32'd2, 32'd511);
    set_mix(MIX_BOTH);
    queue_random(155);
    drain();

    set_layout($urandom, $urandom, $urandom_range(31));
    set_mix(MIX_NONE);
    queue_random(155);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (barrier_verdicts_due.size() != 0) begin
      $error("%0d predicted results never arrived", barrier_verdicts_due.size());
      error_count++;
    end
    $display("tb_top: %0d result beats over %0d register layouts, %0d errors",
             beats_checked, layouts_written, error_count);
    $display("tb_top: global %0d, none %0d, already %0d, recorded %0d, overflow %0d, cleared %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gwb_pkg.sv
sv/gwb_gen_unit.sv
sv/gwb_remset.sv
sv/generational_write_barrier_top.sv
sv/gwb_checker.sv
tb/tb_top.sv
